// ===== design/three_plateau_interpolator_macros.svh =====
// ---------------------------------------------------------------------------
// three_plateau_interpolator_macros.svh
// Assertion shorthands for the three plateau interpolator.
// ---------------------------------------------------------------------------
`ifndef THREE_PLATEAU_INTERPOLATOR_MACROS_SVH
`define THREE_PLATEAU_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define TPI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles.
`define TPI_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// ===== design/tpi_pkg.sv =====
// ---------------------------------------------------------------------------
// tpi_pkg
// Shared constants, register codes and stage types of the interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package tpi_pkg;

   localparam int DATA_W       = 32;
   localparam int REG_COUNT    = 7;
   localparam int ADDR_W       = $clog2(4 * REG_COUNT);
   localparam int DIV_STEPS    = DATA_W;
   localparam int FRONT_STAGES = 2;
   // registers from an accepted item to the result strobe
   localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + 1;

   typedef enum logic [ADDR_W-3:0] {
      REG_IN_MIN          = 3'd0,
      REG_IN_NOMINAL_LOW  = 3'd1,
      REG_IN_NOMINAL_HIGH = 3'd2,
      REG_IN_MAX          = 3'd3,
      REG_OUT_LOW         = 3'd4,
      REG_OUT_NOMINAL     = 3'd5,
      REG_OUT_HIGH        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] in_min;
      logic signed [DATA_W-1:0] in_nominal_low;
      logic signed [DATA_W-1:0] in_nominal_high;
      logic signed [DATA_W-1:0] in_max;
      logic signed [DATA_W-1:0] out_low;
      logic signed [DATA_W-1:0] out_nominal;
      logic signed [DATA_W-1:0] out_high;
   } cfg_type;

   // One slot of the divider chain. lo_q holds the dividend bits still to
   // be shifted in; quotient bits enter at its bottom.
   typedef struct packed {
      logic                     valid;
      logic [DATA_W-1:0]        rem;
      logic [DATA_W-1:0]        lo_q;
      logic [DATA_W-1:0]        den;
      logic signed [DATA_W-1:0] y0;
      logic                     neg;
   } div_stage_type;

endpackage

`default_nettype wire

// ===== design/tpi_front.sv =====
// ---------------------------------------------------------------------------
// tpi_front
// Segment select and ramp operands (stage 1), magnitude product (stage 2).
// ---------------------------------------------------------------------------
`default_nettype none

module tpi_front
   import tpi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_in,
   input  logic signed [DATA_W-1:0] sample,
   input  cfg_type                  cfg,
   output div_stage_type            stage_out
);

   logic signed [DATA_W:0] s_x;
   logic signed [DATA_W:0] num_a, den_a, dy_a, dy_a_r;
   logic signed [DATA_W:0] num_b, den_b, dy_b, dy_b_r;

   logic                     sel_valid_ff;
   logic [DATA_W-1:0]        num_ff, num_in;
   logic [DATA_W-1:0]        den_ff, den_in;
   logic [DATA_W-1:0]        mag_ff, mag_in;
   logic signed [DATA_W-1:0] y0_ff, y0_in;
   logic                     neg_ff, neg_in;

   logic [2*DATA_W-1:0] prod;
   div_stage_type       stage_ff, stage_in;

   assign s_x = {sample[DATA_W-1], sample};

   // both ramps in parallel, picked below
   assign num_a  = s_x - {cfg.in_min[DATA_W-1], cfg.in_min};
   assign den_a  = {cfg.in_nominal_low[DATA_W-1], cfg.in_nominal_low}
                 - {cfg.in_min[DATA_W-1], cfg.in_min};
   assign dy_a   = {cfg.out_nominal[DATA_W-1], cfg.out_nominal}
                 - {cfg.out_low[DATA_W-1], cfg.out_low};
   assign dy_a_r = {cfg.out_low[DATA_W-1], cfg.out_low}
                 - {cfg.out_nominal[DATA_W-1], cfg.out_nominal};

   assign num_b  = s_x - {cfg.in_nominal_high[DATA_W-1], cfg.in_nominal_high};
   assign den_b  = {cfg.in_max[DATA_W-1], cfg.in_max}
                 - {cfg.in_nominal_high[DATA_W-1], cfg.in_nominal_high};
   assign dy_b   = {cfg.out_high[DATA_W-1], cfg.out_high}
                 - {cfg.out_nominal[DATA_W-1], cfg.out_nominal};
   assign dy_b_r = {cfg.out_nominal[DATA_W-1], cfg.out_nominal}
                 - {cfg.out_high[DATA_W-1], cfg.out_high};

   // plateaus go through the divider as 0 / 1
   always_comb begin
      num_in = '0;
      den_in = DATA_W'(1);
      mag_in = '0;
      neg_in = 1'b0;
      y0_in  = cfg.out_high;
      if (sample < cfg.in_min) begin
         y0_in = cfg.out_low;
      end else if (sample < cfg.in_nominal_low) begin
         num_in = num_a[DATA_W-1:0];
         den_in = den_a[DATA_W-1:0];
         neg_in = dy_a[DATA_W];
         mag_in = dy_a[DATA_W] ? dy_a_r[DATA_W-1:0] : dy_a[DATA_W-1:0];
         y0_in  = cfg.out_low;
      end else if (sample < cfg.in_nominal_high) begin
         y0_in = cfg.out_nominal;
      end else if (sample < cfg.in_max) begin
         num_in = num_b[DATA_W-1:0];
         den_in = den_b[DATA_W-1:0];
         neg_in = dy_b[DATA_W];
         mag_in = dy_b[DATA_W] ? dy_b_r[DATA_W-1:0] : dy_b[DATA_W-1:0];
         y0_in  = cfg.out_nominal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= valid_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      mag_ff <= mag_in;
      y0_ff  <= y0_in;
      neg_ff <= neg_in;
   end

   assign prod = num_ff * mag_ff;

   always_comb begin
      stage_in.valid = sel_valid_ff;
      stage_in.rem   = prod[2*DATA_W-1:DATA_W];
      stage_in.lo_q  = prod[DATA_W-1:0];
      stage_in.den   = den_ff;
      stage_in.y0    = y0_ff;
      stage_in.neg   = neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ===== design/tpi_div_cell.sv =====
// ---------------------------------------------------------------------------
// tpi_div_cell
// One restoring-division step: shift in a dividend bit, trial subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module tpi_div_cell
   import tpi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type stage_in,
   output div_stage_type stage_out
);

   logic [DATA_W:0] shifted;
   logic [DATA_W:0] diff;
   logic            fit;
   div_stage_type   stage_ff, next_in;

   assign shifted = {stage_in.rem, stage_in.lo_q[DATA_W-1]};
   assign diff    = shifted - {1'b0, stage_in.den};
   assign fit     = shifted >= {1'b0, stage_in.den};

   always_comb begin
      next_in      = stage_in;
      next_in.rem  = fit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      next_in.lo_q = {stage_in.lo_q[DATA_W-2:0], fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= next_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ===== design/three_plateau_interpolator.sv =====
// ---------------------------------------------------------------------------
// three_plateau_interpolator
// Maps signed Q16.16 samples through a three plateau piecewise-linear curve.
// ---------------------------------------------------------------------------
//  channel   ports                               direction   handshake
//  request   start, busy, req_sample             in          start & !busy
//  response  rsp_strobe, rsp_mapped              out         strobe, one cycle
//  csr       psel penable pwrite paddr pwdata    in/out      APB, pready tied 1
//            prdata pready
//
//  One item per cycle; each result is strobed after these registered steps:
//  segment select, product, 32 divider cells (one quotient bit each), sum.
//  busy stays low; the divider chain is fully pipelined.
//  Synchronous reset zeroes the curve registers and empties the chain.
//  The receiver cannot stall, so nothing backs up.
// ---------------------------------------------------------------------------
`default_nettype none

module three_plateau_interpolator
   import tpi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_mapped,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   cfg_type       cfg_ff;
   csr_index_type csr_index;
   logic          csr_write;

   div_stage_type chain [DIV_STEPS+1];
   div_stage_type tail;

   logic                     strobe_ff;
   logic signed [DATA_W-1:0] mapped_ff, mapped_in;

   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[ADDR_W-1:2]);
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IN_MIN:          cfg_ff.in_min          <= pwdata;
            REG_IN_NOMINAL_LOW:  cfg_ff.in_nominal_low  <= pwdata;
            REG_IN_NOMINAL_HIGH: cfg_ff.in_nominal_high <= pwdata;
            REG_IN_MAX:          cfg_ff.in_max          <= pwdata;
            REG_OUT_LOW:         cfg_ff.out_low         <= pwdata;
            REG_OUT_NOMINAL:     cfg_ff.out_nominal     <= pwdata;
            REG_OUT_HIGH:        cfg_ff.out_high        <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IN_MIN:          prdata = cfg_ff.in_min;
         REG_IN_NOMINAL_LOW:  prdata = cfg_ff.in_nominal_low;
         REG_IN_NOMINAL_HIGH: prdata = cfg_ff.in_nominal_high;
         REG_IN_MAX:          prdata = cfg_ff.in_max;
         REG_OUT_LOW:         prdata = cfg_ff.out_low;
         REG_OUT_NOMINAL:     prdata = cfg_ff.out_nominal;
         REG_OUT_HIGH:        prdata = cfg_ff.out_high;
         default:             prdata = '0;
      endcase
   end

   tpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start & ~busy),
      .sample    (req_sample),
      .cfg       (cfg_ff),
      .stage_out (chain[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      tpi_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   assign tail = chain[DIV_STEPS];

   // quotient is below |dy|, so the sum lands between the two end outputs
   assign mapped_in = tail.neg ? (tail.y0 - $signed(tail.lo_q))
                               : (tail.y0 + $signed(tail.lo_q));

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tail.valid;
      end
      mapped_ff <= mapped_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_mapped = mapped_ff;

`include "three_plateau_interpolator_macros.svh"

   `TPI_ASSERT_DELAY(a_item_gives_result, clock, reset, start && !busy, LATENCY, rsp_strobe, "accepted item produced no result")
   `TPI_ASSERT_NOW(a_result_has_item, clock, reset, rsp_strobe, $past(start && !busy, LATENCY), "result without an accepted item")
   `TPI_ASSERT_NOW(a_div_rem_bound, clock, reset, tail.valid, tail.rem < tail.den, "divider remainder not below divisor")

endmodule

`default_nettype wire

// ===== test/tb_three_plateau_interpolator.sv =====
// ---------------------------------------------------------------------------
// tb_three_plateau_interpolator
// Self-checking bench for the three plateau piecewise-linear interpolator.
// The curve registers are loaded over the CSR port and read back. Samples
// go in through start/busy. Each strobed result is checked against the
// directed value or an in-bench model of the curve. A short directed table
// comes first, then random curves and samples, mostly with random gaps.
// ---------------------------------------------------------------------------

module tb_three_plateau_interpolator
   import tpi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_DIRECTED  = 25;
   localparam int NUM_CURVES    = 5;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int MAX_GAP       = 17;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      int unsigned curve_sel;
      logic [31:0] sample;
      bit          known;
      logic [31:0] mapped;
   } directed_row_type;

   typedef struct {
      logic [31:0] sample;
      logic [31:0] mapped;
   } pending_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [DATA_W-1:0] req_sample = '0;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_mapped;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   three_plateau_interpolator DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_sample (req_sample),
      .rsp_strobe (rsp_strobe),
      .rsp_mapped (rsp_mapped),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #1 clock = ~clock;

   // curve 0 is the reset state and is never written
   cfg_type directed_curves [NUM_CURVES] = '{
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      '{32'hfffc_0000, 32'hffff_0000, 32'h0001_0000, 32'h0004_0000,
        32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff},
      // breakpoints out of order
      '{32'h0005_0000, 32'hfffb_0000, 32'h000a_0000, 32'hfffd_0000,
        32'h0000_0001, 32'h0000_0002, 32'h0000_0003},
      // widest ramp, largest output swing
      '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000},
      // two-plateau form
      '{32'h0000_0000, 32'h0008_0000, 32'h0008_0000, 32'h0008_0000,
        32'h0000_0000, 32'h0005_0000, 32'h0005_0000}
   };

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{0, 32'h8000_0000, 1, 32'h0000_0000},
      '{0, 32'h7fff_ffff, 1, 32'h0000_0000},
      '{0, 32'h0000_0000, 1, 32'h0000_0000},
      '{1, 32'h8000_0000, 1, 32'h8000_0000},
      '{1, 32'h7fff_ffff, 1, 32'h7fff_ffff},
      '{1, 32'hfffc_0000, 1, 32'h8000_0000},
      '{1, 32'hffff_0000, 1, 32'h0001_0000},
      '{1, 32'h0000_0000, 1, 32'h0001_0000},
      '{1, 32'h0001_0000, 1, 32'h0001_0000},
      '{1, 32'h0004_0000, 1, 32'h7fff_ffff},
      '{1, 32'h0003_ffff, 0, 32'h0},
      '{1, 32'hfffd_8000, 0, 32'h0},
      '{2, 32'h0000_0000, 1, 32'h0000_0001},
      '{2, 32'h0007_0000, 1, 32'h0000_0002},
      '{2, 32'h0014_0000, 1, 32'h0000_0003},
      '{2, 32'h7fff_ffff, 1, 32'h0000_0003},
      '{3, 32'h8000_0000, 1, 32'h7fff_ffff},
      '{3, 32'h7fff_fffe, 0, 32'h0},
      '{3, 32'h0000_0000, 0, 32'h0},
      '{3, 32'hffff_ffff, 0, 32'h0},
      '{3, 32'h7fff_ffff, 1, 32'h0000_0000},
      '{4, 32'h0004_0000, 1, 32'h0002_8000},
      '{4, 32'h0008_0000, 1, 32'h0005_0000},
      '{4, 32'hffff_ffff, 1, 32'h0000_0000},
      '{4, 32'h0001_0000, 1, 32'h0000_a000}
   };

   cfg_type     curve;
   pending_type pending_mapped [$];
   bit          allow_gaps;
   int          fail_count = 0;
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          curves_loaded = 0;

   // ramp from (x0,y0) to (x1,y1), quotient truncated toward zero
   function automatic longint ramp_value(longint s, longint x0, longint x1,
                                         longint y0, longint y1);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] mag;
      logic [63:0] quot;
      longint      dy;
      num  = s - x0;
      den  = x1 - x0;
      dy   = y1 - y0;
      mag  = (dy < 0) ? -dy : dy;
      quot = (num * mag) / den;
      return (dy < 0) ? y0 - $signed(quot) : y0 + $signed(quot);
   endfunction

   function automatic logic [31:0] interp_mapped(cfg_type c, logic [31:0] raw);
      longint s;
      longint r;
      s = $signed(raw);
      if (s < longint'(c.in_min))
         r = c.out_low;
      else if (s < longint'(c.in_nominal_low))
         r = ramp_value(s, c.in_min, c.in_nominal_low, c.out_low, c.out_nominal);
      else if (s < longint'(c.in_nominal_high))
         r = c.out_nominal;
      else if (s < longint'(c.in_max))
         r = ramp_value(s, c.in_nominal_high, c.in_max, c.out_nominal, c.out_high);
      else
         r = c.out_high;
      return r[31:0];
   endfunction

   function automatic logic [31:0] curve_field(cfg_type c, csr_index_type idx);
      case (idx)
         REG_IN_MIN:          return c.in_min;
         REG_IN_NOMINAL_LOW:  return c.in_nominal_low;
         REG_IN_NOMINAL_HIGH: return c.in_nominal_high;
         REG_IN_MAX:          return c.in_max;
         REG_OUT_LOW:         return c.out_low;
         REG_OUT_NOMINAL:     return c.out_nominal;
         default:             return c.out_high;
      endcase
   endfunction

   function automatic void report_mismatch(string what, logic [31:0] key,
                                           logic [31:0] exp_val, logic [31:0] act);
      fail_count++;
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t mismatch %s (%h): expected %h, got %h",
                  $realtime, what, key, exp_val, act);
   endfunction

   // biased toward the extremes and toward small Q16.16 values
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         4, 5:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic cfg_type pick_curve();
      cfg_type        c;
      logic [31:0]    bp [4];
      logic [31:0]    tmp;
      for (int i = 0; i < 4; i++)
         bp[i] = pick_word();
      // mostly well-ordered curves, a few scrambled ones
      if ($urandom_range(0, 4) != 0) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
               if ($signed(bp[j]) > $signed(bp[j+1])) begin
                  tmp = bp[j];
                  bp[j] = bp[j+1];
                  bp[j+1] = tmp;
               end
      end
      c.in_min          = bp[0];
      c.in_nominal_low  = bp[1];
      c.in_nominal_high = bp[2];
      c.in_max          = bp[3];
      c.out_low         = pick_word();
      c.out_nominal     = pick_word();
      c.out_high        = pick_word();
      if ($urandom_range(0, 5) == 0) begin
         c.in_nominal_low  = c.in_max;
         c.in_nominal_high = c.in_max;
         c.out_nominal     = c.out_high;
      end
      return c;
   endfunction

   function automatic logic [31:0] pick_sample(cfg_type c);
      longint lo;
      longint span;
      case ($urandom_range(0, 9))
         0: return c.in_min + $urandom_range(0, 8) - 4;
         1: return c.in_nominal_low + $urandom_range(0, 8) - 4;
         2: return c.in_nominal_high + $urandom_range(0, 8) - 4;
         3: return c.in_max + $urandom_range(0, 8) - 4;
         4: return $urandom;
         5: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: begin
            lo   = c.in_min;
            span = longint'(c.in_max) - lo + 1;
            if (span <= 0)
               return $urandom;
            return lo + (longint'($urandom) % span);
         end
      endcase
   endfunction

   task automatic csr_access(input bit wr, input csr_index_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_curve(input cfg_type c);
      csr_index_type idx;
      logic [31:0]   rd;
      idx = idx.first();
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_access(1'b1, idx, curve_field(c, idx), rd);
         idx = idx.next();
      end
      curve = c;
      curves_loaded++;
      idx = idx.first();
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_access(1'b0, idx, '0, rd);
         if (rd !== curve_field(c, idx))
            report_mismatch("csr readback, index", 32'(idx), curve_field(c, idx), rd);
         idx = idx.next();
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_mapped.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_sample(input logic [31:0] s, input bit known,
                              input logic [31:0] typed);
      int          gap;
      pending_type p;
      @(negedge clock);
      start      <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (busy !== 1'b0);
      p.sample = s;
      p.mapped = known ? typed : interp_mapped(curve, s);
      pending_mapped.push_back(p);
      items_sent++;
      gap = allow_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      pending_type p;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_mapped.size() == 0) begin
            fail_count++;
            $display("%0t unexpected result %h", $realtime, rsp_mapped);
         end else begin
            p = pending_mapped.pop_front();
            results_checked++;
            if (rsp_mapped !== p.mapped)
               report_mismatch("mapped for sample", p.sample, p.mapped, rsp_mapped);
         end
      end
   end

   initial begin
      int unsigned active_curve;
      int          phase_len;
      curve        = directed_curves[0];
      active_curve = 0;
      allow_gaps   = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].curve_sel != active_curve) begin
            wait_drained();
            active_curve = directed_rows[i].curve_sel;
            load_curve(directed_curves[active_curve]);
         end
         send_sample(directed_rows[i].sample, directed_rows[i].known,
                     directed_rows[i].mapped);
      end

      while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
         wait_drained();
         load_curve(pick_curve());
         allow_gaps = ($urandom_range(0, 3) != 0);
         phase_len  = $urandom_range(20, 80);
         if (phase_len > NUM_DIRECTED + RANDOM_ITEMS - items_sent)
            phase_len = NUM_DIRECTED + RANDOM_ITEMS - items_sent;
         repeat (phase_len)
            send_sample(pick_sample(curve), 1'b0, '0);
      end

      wait_drained();
      repeat (LATENCY + 5) @(posedge clock);
      if (pending_mapped.size() != 0) begin
         fail_count++;
         $display("%0d results never arrived", pending_mapped.size());
      end
      $display("%0d samples mapped over %0d curves, %0d results checked",
               items_sent, curves_loaded + 1, results_checked);
      $display("%0d failures, %0d mismatches", fail_count, mismatch_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("timeout waiting for the interpolator");
      $display("TEST FAILED");
      $finish;
   end

endmodule
